// File: sv/cwsc_pkg.sv
package cwsc_pkg;

	localparam int COS_TABLE_BITS = 10;
	localparam int COS_SIZE       = 1 << COS_TABLE_BITS;
	localparam int COS_QUARTER    = COS_SIZE >> 2;
	localparam int MAX_COLUMNS    = 4096;
	localparam int AMP            = 32767;
	localparam int QUO_W          = 11;
	localparam longint Q28_ONE     = 64'sd1 << 28;
	localparam longint Q28_HALF    = 64'sd1 << 27;
	localparam longint HALF_PI_Q28 = 64'sd421657428;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_ADV  = 2'd1;
	localparam logic [1:0] MODE_COL  = 2'd2;

	localparam logic [1:0] REG_WAVE_COUNT  = 2'd0;
	localparam logic [1:0] REG_COLOR_COUNT = 2'd1;
	localparam logic [1:0] REG_COLUMN_STEP = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         wave_slot;
		logic [15:0]        wave_freq;
		logic [15:0]        wave_phase;
		logic signed [15:0] wave_step;
		logic [11:0]        column_number;
	} in_beat_t;

	typedef struct packed {
		logic [9:0]  color_index;
		logic [15:0] column_x;
	} out_beat_t;

	typedef struct packed {
		logic [4:0]  wave_count;
		logic [10:0] color_count;
		logic [4:0]  column_step;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_ADV,
		OP_COL
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  slot;
		logic [15:0] freq;
		logic [15:0] phase;
		logic [15:0] step;
		logic [15:0] x;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ADV,
		BK_SUM,
		BK_DRAIN,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} back_state_t;

	typedef logic signed [15:0] cos_rom_t [COS_SIZE];

	function automatic int quarter_cos(input int u);
		longint theta;
		longint t2;
		longint h;
		theta = (longint'(u) * HALF_PI_Q28) / COS_QUARTER;
		t2 = (theta * theta) / Q28_ONE;
		h = Q28_ONE;
		h = Q28_ONE - ((t2 * h) / Q28_ONE) / 132;
		h = Q28_ONE - ((t2 * h) / Q28_ONE) / 90;
		h = Q28_ONE - ((t2 * h) / Q28_ONE) / 56;
		h = Q28_ONE - ((t2 * h) / Q28_ONE) / 30;
		h = Q28_ONE - ((t2 * h) / Q28_ONE) / 12;
		h = Q28_ONE - ((t2 * h) / Q28_ONE) / 2;
		if (h < 0) h = 0;
		if (h > Q28_ONE) h = Q28_ONE;
		return int'((h * AMP + Q28_HALF) / Q28_ONE);
	endfunction

	function automatic cos_rom_t build_cos();
		cos_rom_t rom;
		int quad;
		int u;
		int v;
		for (int k = 0; k < COS_SIZE; k++) begin
			quad = (k / COS_QUARTER) & 3;
			u = k % COS_QUARTER;
			if (quad == 0) v = quarter_cos(u);
			else if (quad == 1) v = -quarter_cos(COS_QUARTER - u);
			else if (quad == 2) v = -quarter_cos(u);
			else v = quarter_cos(COS_QUARTER - u);
			rom[k] = 16'(v);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos();

endpackage

// File: sv/cosine_wave_sum_color_columns_unit.sv
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready   | in_data  (in_beat_t)
// out     | out | out_valid / out_ready | out_data (out_beat_t)
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Load beats write the wave tables while the back end is idle and mode-3 beats
// are dropped at the front; an advance steps the phase of every active wave.
// A column runs one wave per cycle through the multiply/cosine lookup, then one
// multiply and an 11-step restoring divider.
// Reset clears control state; wave tables hold garbage until loaded.
// A two-entry queue lets input beats be taken while the back end works or
// while a result waits on out_ready.
module cosine_wave_sum_color_columns_unit #(
	parameter int MAX_WAVES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cwsc_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cwsc_pkg::out_beat_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [10:0]         cfg_data
);
	import cwsc_pkg::*;

	logic [4:0]  wave_count_q;
	logic [10:0] color_count_q;
	logic [4:0]  column_step_q;
	cfg_t        cfg;
	logic        q_full;
	logic        push;
	job_t        push_job;
	logic        job_valid;
	logic        job_ready;
	job_t        job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_count_q  <= 5'd15;
			color_count_q <= 11'd600;
			column_step_q <= 5'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WAVE_COUNT:  wave_count_q <= cfg_data[4:0];
				REG_COLOR_COUNT: color_count_q <= cfg_data;
				REG_COLUMN_STEP: column_step_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.wave_count = wave_count_q;
		if (color_count_q < 11'd4) cfg.color_count = 11'd4;
		else if (color_count_q > 11'd1024) cfg.color_count = 11'd1024;
		else cfg.color_count = color_count_q;
		if (column_step_q == 5'd0) cfg.column_step = 5'd1;
		else if (column_step_q > 5'd16) cfg.column_step = 5'd16;
		else cfg.column_step = column_step_q;
	end

	cwsc_front #(.MAX_WAVES(MAX_WAVES)) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	cwsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop_valid (job_valid),
		.pop_ready (job_ready),
		.pop_job   (job)
	);

	cwsc_back #(.MAX_WAVES(MAX_WAVES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: sv/cwsc_front.sv
module cwsc_front #(
	parameter int MAX_WAVES = 16
) (
	input  logic             in_valid,
	output logic             in_ready,
	input  cwsc_pkg::in_beat_t in_data,
	input  cwsc_pkg::cfg_t   cfg,
	input  logic             q_full,
	output logic             push,
	output cwsc_pkg::job_t   push_job
);
	import cwsc_pkg::*;

	logic        keep;
	logic [16:0] x_full;

	assign in_ready = !q_full;
	assign x_full   = 17'(in_data.column_number) * 17'(cfg.column_step);

	always_comb begin
		keep = 1'b0;
		push_job.op = OP_LOAD;
		unique case (in_data.mode)
			MODE_LOAD: begin
				keep = 32'(in_data.wave_slot) < MAX_WAVES;
				push_job.op = OP_LOAD;
			end
			MODE_ADV: begin
				keep = 1'b1;
				push_job.op = OP_ADV;
			end
			MODE_COL: begin
				keep = 13'(in_data.column_number) < 13'(MAX_COLUMNS);
				push_job.op = OP_COL;
			end
			default: keep = 1'b0;
		endcase
	end

	assign push_job.slot  = in_data.wave_slot;
	assign push_job.freq  = in_data.wave_freq;
	assign push_job.phase = in_data.wave_phase;
	assign push_job.step  = in_data.wave_step;
	assign push_job.x     = x_full[15:0];
	assign push           = in_valid && in_ready && keep;

endmodule

// File: sv/cwsc_queue.sv
module cwsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cwsc_pkg::job_t push_job,
	output logic           full,
	output logic           pop_valid,
	input  logic           pop_ready,
	output cwsc_pkg::job_t pop_job
);
	import cwsc_pkg::*;

	job_t       slots_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = count_q == 2'd2;
	assign pop_valid = count_q != 2'd0;
	assign pop_job   = slots_q[rptr_q];
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) slots_q[wptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: sv/cwsc_back.sv
module cwsc_back #(
	parameter int MAX_WAVES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cwsc_pkg::cfg_t      cfg,
	input  logic                job_valid,
	output logic                job_ready,
	input  cwsc_pkg::job_t      job,
	output logic                out_valid,
	input  logic                out_ready,
	output cwsc_pkg::out_beat_t out_data
);
	import cwsc_pkg::*;

	localparam int WIDX = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
	localparam int CW   = $clog2(MAX_WAVES + 1);
	localparam int SUMW = $clog2(MAX_WAVES * AMP + 1) + 1;
	localparam int OFFW = $clog2(2 * MAX_WAVES * AMP + 1);
	localparam int NUMW = OFFW + QUO_W;
	localparam logic [OFFW-1:0] AMP_W = OFFW'(AMP);

	logic [15:0] freq_mem  [MAX_WAVES];
	logic [15:0] phase_mem [MAX_WAVES];
	logic [15:0] step_mem  [MAX_WAVES];

	back_state_t state_q, state_d;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          n_act;
	logic [WIDX-1:0]        rd_idx;
	logic                   last;
	logic [15:0]            x_q;
	logic [15:0]            ang_s1;
	logic                   vld_s1_q;
	logic signed [SUMW-1:0] sum_q;
	logic [OFFW-1:0]        namp;
	logic [OFFW-1:0]        den;
	logic [OFFW-1:0]        off;
	logic [NUMW-1:0]        rem_q;
	logic [NUMW-1:0]        dsh_q;
	logic [QUO_W-1:0]       quo_q;
	logic [3:0]             bit_q;
	logic [31:0]            prod;
	logic [10:0]            cnt_m1;
	logic [10:0]            color;
	logic                   slot_free;
	logic                   take;
	logic                   out_valid_q;
	out_beat_t              out_q;

	always_comb begin
		if (cfg.wave_count == 5'd0) n_act = CW'(1);
		else if (32'(cfg.wave_count) > MAX_WAVES) n_act = CW'(MAX_WAVES);
		else n_act = CW'(cfg.wave_count);
	end

	assign rd_idx    = idx_q[WIDX-1:0];
	assign last      = idx_q == n_act - CW'(1);
	assign slot_free = !out_valid_q || out_ready;
	assign take      = job_valid && job_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					unique case (job.op)
						OP_ADV:  state_d = BK_ADV;
						OP_COL:  state_d = BK_SUM;
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_ADV:   if (last) state_d = BK_IDLE;
			BK_SUM:   if (last) state_d = BK_DRAIN;
			BK_DRAIN: state_d = BK_MUL;
			BK_MUL:   state_d = BK_DIV;
			BK_DIV:   if (bit_q == 4'd0) state_d = BK_OUT;
			BK_OUT:   if (slot_free) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_ready = state_q == BK_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// wave tables: load from idle, phase update during advance
	always_ff @(posedge clk) begin
		if (take && job.op == OP_LOAD) begin
			freq_mem[WIDX'(job.slot)]  <= job.freq;
			phase_mem[WIDX'(job.slot)] <= job.phase;
			step_mem[WIDX'(job.slot)]  <= job.step;
		end else if (state_q == BK_ADV) begin
			phase_mem[rd_idx] <= phase_mem[rd_idx] + step_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			vld_s1_q <= 1'b0;
		end else begin
			vld_s1_q <= state_q == BK_SUM;
			if (state_q == BK_ADV || state_q == BK_SUM) idx_q <= idx_q + CW'(1);
			else idx_q <= '0;
		end
	end

	assign prod = 32'(x_q) * 32'(freq_mem[rd_idx]);
	assign namp = OFFW'(n_act) * AMP_W;
	assign den  = namp << 1;
	// sum is within +/- n*AMP, so the wrapped add lands on the true offset
	assign off  = OFFW'(sum_q) + namp;

	always_ff @(posedge clk) begin
		if (take) begin
			x_q   <= job.x;
			sum_q <= '0;
		end else if (vld_s1_q) begin
			sum_q <= sum_q + SUMW'(COS_ROM[ang_s1[15 -: COS_TABLE_BITS]]);
		end
		ang_s1 <= prod[15:0] - phase_mem[rd_idx];
		if (state_q == BK_MUL) begin
			rem_q <= NUMW'(cfg.color_count) * NUMW'(off);
			dsh_q <= NUMW'(den) << (QUO_W - 1);
			quo_q <= '0;
			bit_q <= 4'(QUO_W - 1);
		end else if (state_q == BK_DIV) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
			bit_q <= bit_q - 4'd1;
		end
	end

	assign cnt_m1 = cfg.color_count - 11'd1;
	assign color  = (quo_q > cnt_m1) ? cnt_m1 : quo_q;

	always_ff @(posedge clk) begin
		if (state_q == BK_OUT && slot_free) begin
			out_q.color_index <= color[9:0];
			out_q.column_x    <= x_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == BK_OUT && slot_free) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_s1_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1_q |-> (state_q == BK_SUM || state_q == BK_DRAIN))
		else $error("angle stage valid outside summation");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SUM || state_q == BK_ADV) |-> idx_q < n_act)
		else $error("wave index past active count");
	a_div_bits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DIV |-> bit_q <= 4'(QUO_W - 1))
		else $error("divider bit count out of range");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_OUT && slot_free) |=> (out_valid_q && state_q == BK_IDLE))
		else $error("result not posted");

endmodule
